/* rtl/core/psg_beeper_mixer_iir_resampler_core_defines.svh */
// assertion macros used by the checker file of the beeper mixer core
// no dependencies; included by bare file name
`ifndef PSG_BEEPER_MIXER_IIR_RESAMPLER_CORE_DEFINES_SVH
`define PSG_BEEPER_MIXER_IIR_RESAMPLER_CORE_DEFINES_SVH

// property checked at every clock edge outside reset
`define PSGBM_ASSERT(lbl, ck, rstn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
    else $error("psgbm check failed");

// signal holds its value in the cycle after cond
`define PSGBM_ASSERT_HOLD(lbl, ck, rstn, cond, sig) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("psgbm hold check failed");

`endif

/* rtl/core/psgbm_pkg.sv */
// shared constants, types and table builders of the beeper mixer core
// no dependencies; used by every module of the core by scoped names
`timescale 1ns / 1ps
`default_nettype none

package psgbm_pkg;

  localparam int unsigned MaxPerChannelDef = 6553;
  localparam int unsigned ToneChannelsDef  = 4;
  localparam int unsigned QueueDepthDef    = 2;

  // beeper at voice 0, tone channel c at voice c+1
  localparam int unsigned NumVoices   = 5;
  localparam int unsigned AttnLevels  = 16;
  localparam int unsigned AttnW       = 4;
  localparam int unsigned BaseW       = 13;
  localparam int unsigned RomW        = 16;
  localparam int unsigned RomFrac     = 15;
  localparam int unsigned ProdW       = BaseW + RomW;
  localparam int unsigned SumW        = 15;
  localparam int unsigned LevelW      = 16;
  localparam int unsigned VolW        = 7;
  localparam int unsigned PeriodW     = 16;
  localparam int unsigned VolEntries  = 1 << VolW;
  localparam int unsigned PercentFull = 100;
  localparam int unsigned FilterShift = 4;
  localparam int unsigned FilterRound = (1 << FilterShift) - 1;

  localparam logic [AttnW-1:0]   AttnOff           = 4'd15;
  localparam logic [VolW-1:0]    VolumeRst         = 7'd50;
  localparam logic [PeriodW-1:0] ResamplePeriodRst = 16'd1000;
  localparam logic [PeriodW-1:0] TickPeriodRst     = 16'd16;

  // input tdata layout
  localparam int unsigned ChanStride = 1 + AttnW;
  localparam int unsigned BeeperBit  = 4 * ChanStride;
  localparam int unsigned PausedBit  = BeeperBit + 1;
  localparam int unsigned InDataW    = 24;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned CfgAddrW   = 5;
  localparam int unsigned CfgDataW   = 32;

  // q1.15 gain, 2 dB steps
  localparam logic [RomW-1:0] AttnRom [AttnLevels] = '{
    16'd32768, 16'd26029, 16'd20675, 16'd16423, 16'd13045, 16'd10362, 16'd8231, 16'd6538,
    16'd5193,  16'd4125,  16'd3277,  16'd2603,  16'd2068,  16'd1642,  16'd1305, 16'd1036
  };

  typedef enum logic [2:0] {
    RegBeeperVol      = 3'd0,
    RegTone0Vol       = 3'd1,
    RegTone1Vol       = 3'd2,
    RegTone2Vol       = 3'd3,
    RegTone3Vol       = 3'd4,
    RegResamplePeriod = 3'd5,
    RegTickPeriod     = 3'd6
  } reg_idx_t;

  typedef logic [NumVoices-1:0][BaseW-1:0] base_vec_t;

  typedef struct packed {
    logic [PeriodW-1:0] resample_period;
    logic [PeriodW-1:0] tick_period;
  } timing_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  typedef logic [BaseW-1:0] base_tbl_t [VolEntries];

  // channel level per volume code, codes above full scale saturate
  function automatic base_tbl_t base_table(input int unsigned max_lvl);
    base_tbl_t   tbl;
    int unsigned vs;
    for (int unsigned v = 0; v < VolEntries; v++) begin
      vs     = (v > PercentFull) ? PercentFull : v;
      tbl[v] = BaseW'((max_lvl * vs) / PercentFull);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/psgbm_regs.sv */
// configuration register file with apb-style access and per-voice level lookup
// depends on psgbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psgbm_regs #(
  parameter int unsigned MAX_PER_CHANNEL = psgbm_pkg::MaxPerChannelDef
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [psgbm_pkg::CfgAddrW-1:0]     cfg_paddr,
  input  wire logic [psgbm_pkg::CfgDataW-1:0]     cfg_pwdata,
  output logic      [psgbm_pkg::CfgDataW-1:0]     cfg_prdata,
  output psgbm_pkg::base_vec_t                    bases,
  output psgbm_pkg::timing_t                      timing
);

  localparam psgbm_pkg::base_tbl_t BaseTbl = psgbm_pkg::base_table(MAX_PER_CHANNEL);

  logic [psgbm_pkg::NumVoices-1:0][psgbm_pkg::VolW-1:0] vol_r, vol_nxt;
  psgbm_pkg::base_vec_t                                 base_r, base_nxt;
  logic [psgbm_pkg::PeriodW-1:0]                        period_r, period_nxt;
  logic [psgbm_pkg::PeriodW-1:0]                        tick_r, tick_nxt;
  logic                                                 wr_en;
  psgbm_pkg::reg_idx_t                                  idx;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx   = psgbm_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    vol_nxt    = vol_r;
    base_nxt   = base_r;
    period_nxt = period_r;
    tick_nxt   = tick_r;
    if (wr_en) begin
      case (idx)
        psgbm_pkg::RegBeeperVol, psgbm_pkg::RegTone0Vol, psgbm_pkg::RegTone1Vol,
        psgbm_pkg::RegTone2Vol, psgbm_pkg::RegTone3Vol: begin
          vol_nxt[idx]  = cfg_pwdata[psgbm_pkg::VolW-1:0];
          base_nxt[idx] = BaseTbl[cfg_pwdata[psgbm_pkg::VolW-1:0]];
        end
        psgbm_pkg::RegResamplePeriod: period_nxt = cfg_pwdata[psgbm_pkg::PeriodW-1:0];
        psgbm_pkg::RegTickPeriod:     tick_nxt   = cfg_pwdata[psgbm_pkg::PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      psgbm_pkg::RegBeeperVol, psgbm_pkg::RegTone0Vol, psgbm_pkg::RegTone1Vol,
      psgbm_pkg::RegTone2Vol, psgbm_pkg::RegTone3Vol:
        cfg_prdata = psgbm_pkg::CfgDataW'(vol_r[idx]);
      psgbm_pkg::RegResamplePeriod: cfg_prdata = psgbm_pkg::CfgDataW'(period_r);
      psgbm_pkg::RegTickPeriod:     cfg_prdata = psgbm_pkg::CfgDataW'(tick_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned v = 0; v < psgbm_pkg::NumVoices; v++) begin
        vol_r[v]  <= psgbm_pkg::VolumeRst;
        base_r[v] <= BaseTbl[psgbm_pkg::VolumeRst];
      end
      period_r <= psgbm_pkg::ResamplePeriodRst;
      tick_r   <= psgbm_pkg::TickPeriodRst;
    end else begin
      vol_r    <= vol_nxt;
      base_r   <= base_nxt;
      period_r <= period_nxt;
      tick_r   <= tick_nxt;
    end
  end

  assign bases                  = base_r;
  assign timing.resample_period = period_r;
  assign timing.tick_period     = tick_r;

endmodule

`default_nettype wire

/* rtl/core/psgbm_front.sv */
// front end: accepts scan ticks, runs the resample countdown, scales channel levels
// depends on psgbm_pkg; feeds psgbm_queue
`timescale 1ns / 1ps
`default_nettype none

module psgbm_front #(
  parameter int unsigned TONE_CHANNELS = psgbm_pkg::ToneChannelsDef,
  parameter int unsigned ENTRY_W       = (TONE_CHANNELS + 1) * psgbm_pkg::BaseW + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [psgbm_pkg::InDataW-1:0]    in_tdata,
  input  psgbm_pkg::base_vec_t                  bases,
  input  psgbm_pkg::timing_t                    timing,
  input  psgbm_pkg::qstat_t                     qstat,
  output logic                                  q_push,
  output logic      [ENTRY_W-1:0]               q_wdata
);

  localparam int unsigned TermsW = TONE_CHANNELS * psgbm_pkg::BaseW;

  logic [psgbm_pkg::PeriodW-1:0] cd_r, cd_nxt, cd_sum;
  logic                          accept;
  logic                          due;
  logic                          emit;
  logic [psgbm_pkg::BaseW-1:0]   beep_term;
  logic [TermsW-1:0]             terms;

  assign in_tready = !qstat.full;
  assign accept    = in_tvalid && in_tready;

  // countdown wraps modulo 2^16
  assign due    = cd_r <= timing.tick_period;
  assign cd_sum = due ? cd_r + timing.resample_period : cd_r;
  assign cd_nxt = accept ? cd_sum - timing.tick_period : cd_r;
  assign emit   = due && !in_tdata[psgbm_pkg::PausedBit];

  for (genvar c = 0; c < TONE_CHANNELS; c++) begin : g_chan
    logic [psgbm_pkg::AttnW-1:0] attn;
    logic                        on;
    logic [psgbm_pkg::ProdW-1:0] prod;

    assign attn = in_tdata[c*psgbm_pkg::ChanStride+1 +: psgbm_pkg::AttnW];
    assign on   = in_tdata[c*psgbm_pkg::ChanStride] && (attn != psgbm_pkg::AttnOff);
    assign prod = psgbm_pkg::ProdW'(bases[c+1]) * psgbm_pkg::ProdW'(psgbm_pkg::AttnRom[attn]);
    // gain is at most 1.0, so the scaled level fits the base width
    assign terms[c*psgbm_pkg::BaseW +: psgbm_pkg::BaseW] =
      on ? prod[psgbm_pkg::RomFrac +: psgbm_pkg::BaseW] : '0;
  end

  assign beep_term = in_tdata[psgbm_pkg::BeeperBit] ? bases[0] : '0;

  assign q_push  = accept;
  assign q_wdata = {emit, beep_term, terms};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r <= psgbm_pkg::ResamplePeriodRst;
    end else begin
      cd_r <= cd_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/psgbm_queue.sv */
// small register queue between the front end and the filter back end
// depends on psgbm_pkg
`timescale 1ns / 1ps
`default_nettype none

module psgbm_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = psgbm_pkg::QueueDepthDef
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output psgbm_pkg::qstat_t     qstat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign qstat.full  = cnt_r == CntW'(DEPTH);
  assign qstat.valid = cnt_r != '0;
  assign rdata       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/psgbm_back.sv */
// back end: sums voice levels, runs the one-pole low-pass filter, holds the result
// depends on psgbm_pkg; drained from psgbm_queue
`timescale 1ns / 1ps
`default_nettype none

module psgbm_back #(
  parameter int unsigned TONE_CHANNELS = psgbm_pkg::ToneChannelsDef,
  parameter int unsigned ENTRY_W       = (TONE_CHANNELS + 1) * psgbm_pkg::BaseW + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  psgbm_pkg::qstat_t                     qstat,
  input  wire logic [ENTRY_W-1:0]               q_rdata,
  output logic                                  q_pop,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [psgbm_pkg::OutDataW-1:0]   out_tdata
);

  localparam int unsigned BeepLsb = TONE_CHANNELS * psgbm_pkg::BaseW;
  localparam int unsigned EmitBit = ENTRY_W - 1;

  logic                              sum_v_r, sum_v_nxt;
  logic [psgbm_pkg::SumW-1:0]        sum_r, sum_c;
  logic                              emit_r;
  logic [psgbm_pkg::LevelW-1:0]      level_r, level_nxt;
  logic                              out_v_r, out_v_nxt;
  logic [psgbm_pkg::SumW-1:0]        sample_r;
  logic                              adv_s;
  logic                              adv_f;
  logic signed [psgbm_pkg::LevelW:0] diff, adj, step;

  always_comb begin
    sum_c = psgbm_pkg::SumW'(q_rdata[BeepLsb +: psgbm_pkg::BaseW]);
    for (int unsigned c = 0; c < TONE_CHANNELS; c++) begin
      sum_c = sum_c + psgbm_pkg::SumW'(q_rdata[c*psgbm_pkg::BaseW +: psgbm_pkg::BaseW]);
    end
  end

  // filter stage moves when the output register is free or being drained
  assign adv_f = sum_v_r && (!out_v_r || out_tready);
  assign adv_s = qstat.valid && (!sum_v_r || adv_f);
  assign q_pop = adv_s;

  assign sum_v_nxt = adv_s || (sum_v_r && !adv_f);
  assign out_v_nxt = (out_v_r && !out_tready) || (adv_f && emit_r);

  // step toward the mix by a sixteenth, rounded toward zero
  assign diff      = $signed((psgbm_pkg::LevelW+1)'(sum_r)) -
                     $signed((psgbm_pkg::LevelW+1)'(level_r));
  assign adj       = diff[psgbm_pkg::LevelW] ?
                     diff + $signed((psgbm_pkg::LevelW+1)'(psgbm_pkg::FilterRound)) : diff;
  assign step      = adj >>> psgbm_pkg::FilterShift;
  assign level_nxt = level_r + step[psgbm_pkg::LevelW-1:0];

  always_ff @(posedge clk) begin
    if (adv_s) begin
      sum_r  <= sum_c;
      emit_r <= q_rdata[EmitBit];
    end
    if (adv_f && emit_r) begin
      sample_r <= level_nxt[psgbm_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
      out_v_r <= 1'b0;
      level_r <= '0;
    end else begin
      sum_v_r <= sum_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv_f) begin
        level_r <= level_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = psgbm_pkg::OutDataW'(sample_r);

endmodule

`default_nettype wire

/* rtl/core/psg_beeper_mixer_iir_resampler_core.sv */
// sound mixer core: four tone voices and a beeper, one-pole low-pass, resampler.
// path: an accepted tick passes the queue, then the sum register, then the output register.
// throughput: one tick per cycle while out_tready is high; filter: subtract, round, add.
// reset (rst_n low, synchronous): volumes 50, resample period 1000, tick period 16,
//   filter level 0, countdown 1000, queue and output empty.
// depends on psgbm_pkg, psgbm_regs, psgbm_front, psgbm_queue, psgbm_back
`timescale 1ns / 1ps
`default_nettype none

module psg_beeper_mixer_iir_resampler_core #(
  parameter int unsigned MAX_PER_CHANNEL = psgbm_pkg::MaxPerChannelDef,
  parameter int unsigned TONE_CHANNELS   = psgbm_pkg::ToneChannelsDef,
  parameter int unsigned QUEUE_DEPTH     = psgbm_pkg::QueueDepthDef
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tone0_out, tone0_attn, tone1_out, tone1_attn, tone2_out, tone2_attn,
  // tone3_out, tone3_attn, beeper_out, paused
  input  wire logic [psgbm_pkg::InDataW-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // sample
  output logic      [psgbm_pkg::OutDataW-1:0]   out_tdata,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [psgbm_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  wire logic [psgbm_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic      [psgbm_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned EntryW = (TONE_CHANNELS + 1) * psgbm_pkg::BaseW + 1;

  psgbm_pkg::base_vec_t bases;
  psgbm_pkg::timing_t   timing;
  psgbm_pkg::qstat_t    qstat;
  logic                 q_push;
  logic                 q_pop;
  logic [EntryW-1:0]    q_wdata;
  logic [EntryW-1:0]    q_rdata;

  assign cfg_pready = 1'b1;

  psgbm_regs #(
    .MAX_PER_CHANNEL (MAX_PER_CHANNEL)
  ) u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .bases       (bases),
    .timing      (timing)
  );

  psgbm_front #(
    .TONE_CHANNELS (TONE_CHANNELS),
    .ENTRY_W       (EntryW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .bases     (bases),
    .timing    (timing),
    .qstat     (qstat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  psgbm_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qstat (qstat)
  );

  psgbm_back #(
    .TONE_CHANNELS (TONE_CHANNELS),
    .ENTRY_W       (EntryW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/psgbm_checker.sv */
// port-level checks of the beeper mixer core, bound to the top level
// depends on psgbm_pkg and psg_beeper_mixer_iir_resampler_core_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "psg_beeper_mixer_iir_resampler_core_defines.svh"

module psgbm_checker #(
  parameter int unsigned MAX_PER_CHANNEL = psgbm_pkg::MaxPerChannelDef,
  parameter int unsigned TONE_CHANNELS   = psgbm_pkg::ToneChannelsDef
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [psgbm_pkg::OutDataW-1:0] out_tdata,
  input wire logic                           cfg_pready
);

  localparam logic [psgbm_pkg::OutDataW-1:0] LevelMax =
    psgbm_pkg::OutDataW'((TONE_CHANNELS + 1) * MAX_PER_CHANNEL);

  // filter never overshoots the largest possible mix
  `PSGBM_ASSERT(a_level_bound, clk, rst_n, out_tvalid |-> out_tdata <= LevelMax)
  // nothing comes out in the first cycle after reset
  `PSGBM_ASSERT(a_empty_after_reset, clk, rst_n, $past(!rst_n) |-> !out_tvalid)
  `PSGBM_ASSERT(a_pready_high, clk, rst_n, cfg_pready)
  `PSGBM_ASSERT_HOLD(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tdata)

endmodule

bind psg_beeper_mixer_iir_resampler_core psgbm_checker #(
  .MAX_PER_CHANNEL (MAX_PER_CHANNEL),
  .TONE_CHANNELS   (TONE_CHANNELS)
) u_psgbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
